[sv/swpr_pkg.sv]
// ----------------------------------------------------------------------------
// swpr_pkg: shared types for the sliding window peak range block
// Holds the queue entry carried from the front end to the window engine.
// ----------------------------------------------------------------------------
package swpr_pkg;

  localparam int unsigned CfgBits = 11;

  // one classified sample, as queued between front and back
  typedef struct packed {
    logic [31:0]        sample;  // sign-extended sample
    logic [CfgBits-1:0] len;     // effective window length, 1..WINDOW_MAX
    logic               last;
  } swpr_item_t;

  typedef enum logic [1:0] {
    BeIdle,
    BeScan,
    BeDone
  } swpr_be_state_e;

endpackage

[sv/swpr_ram.sv]
// ----------------------------------------------------------------------------
// swpr_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module swpr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[sv/swpr_front.sv]
// ----------------------------------------------------------------------------
// swpr_front: sample intake
// Sign-extends samples, clamps the window length and queues items.
// ----------------------------------------------------------------------------
module swpr_front #(
  parameter int unsigned WindowMax  = 1024,
  parameter int unsigned SampleBits = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [swpr_pkg::CfgBits-1:0] window_len_q_i,
  input  logic [31:0]                  sample_i,
  input  logic                         last_sample_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output swpr_pkg::swpr_item_t         item_o,
  output logic                         item_valid_o,
  input  logic                         item_ready_i
);
  import swpr_pkg::*;

  localparam int unsigned LenBits = $clog2(WindowMax + 1);

  swpr_item_t q_d [2];
  swpr_item_t q_q [2];
  logic [1:0] cnt_d, cnt_q;
  swpr_item_t in_item;
  logic [LenBits-1:0] len_clamped;
  logic push, pop;

  // window length clamp
  always_comb begin
    if (window_len_q_i == '0) begin
      len_clamped = LenBits'(1);
    end else if (32'(window_len_q_i) > WindowMax) begin
      len_clamped = LenBits'(WindowMax);
    end else begin
      len_clamped = LenBits'(window_len_q_i);
    end
  end

  // classify incoming sample
  always_comb begin
    in_item.sample = 32'(signed'(sample_i[SampleBits-1:0]));
    in_item.len    = CfgBits'(len_clamped);
    in_item.last   = last_sample_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = q_q[0];

  // two-entry queue, head in slot 0
  always_comb begin
    q_d   = q_q;
    cnt_d = cnt_q;
    if (pop) begin
      q_d[0] = q_q[1];
      cnt_d  = cnt_d - 2'd1;
    end
    if (push) begin
      q_d[cnt_d[0]] = in_item;
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

[sv/swpr_back.sv]
// ----------------------------------------------------------------------------
// swpr_back: window engine
// Stores each sample, scans the window through the RAM and tracks the
// largest range; emits the result on the last sample of a set.
// ----------------------------------------------------------------------------
module swpr_back #(
  parameter int unsigned WindowMax = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swpr_pkg::swpr_item_t item_i,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  output logic [31:0]          best_range_o,
  output logic                 had_window_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i
);
  import swpr_pkg::*;

  localparam int unsigned AddrBits = $clog2(WindowMax);
  localparam int unsigned FillBits = $clog2(WindowMax + 1);

  swpr_be_state_e state_d, state_q;
  logic [AddrBits-1:0] wpos_d, wpos_q, raddr_d, raddr_q;
  logic [FillBits-1:0] fill_d, fill_q, left_d, left_q;
  logic [31:0] best_d, best_q, hi_d, hi_q, lo_d, lo_q;
  logic seen_d, seen_q, last_d, last_q, rd_pend_d, rd_pend_q;
  logic ovalid_d, ovalid_q;
  logic [31:0] obest_d, obest_q;
  logic ohad_d, ohad_q;
  logic ram_we;
  logic [AddrBits-1:0] ram_addr;
  logic [31:0] ram_rdata, range;
  logic [FillBits-1:0] fill_inc;
  logic take;

  swpr_ram #(.Width(32), .Depth(WindowMax)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(item_i.sample),
    .rdata_o(ram_rdata)
  );

  assign range        = hi_q - lo_q;
  assign best_range_o = obest_q;
  assign had_window_o = ohad_q;
  assign out_valid_o  = ovalid_q;
  assign fill_inc     = (32'(fill_q) < WindowMax) ? fill_q + FillBits'(1) : fill_q;

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    wpos_d    = wpos_q;
    raddr_d   = raddr_q;
    fill_d    = fill_q;
    left_d    = left_q;
    best_d    = best_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    seen_d    = seen_q;
    last_d    = last_q;
    rd_pend_d = 1'b0;
    ovalid_d  = ovalid_q && !out_ready_i;
    obest_d   = obest_q;
    ohad_d    = ohad_q;
    ram_we    = 1'b0;
    ram_addr  = raddr_q;
    take      = 1'b0;
    item_ready_o = 1'b0;
    case (state_q)
      BeIdle: begin
        item_ready_o = 1'b1;
        take = item_valid_i;
        if (take) begin
          // store the sample, plan a scan over the older window members
          ram_we   = 1'b1;
          ram_addr = wpos_q;
          wpos_d   = (32'(wpos_q) == WindowMax - 1) ? '0 : wpos_q + AddrBits'(1);
          fill_d   = fill_inc;
          hi_d     = item_i.sample;
          lo_d     = item_i.sample;
          last_d   = item_i.last;
          raddr_d  = (wpos_q == '0) ? AddrBits'(WindowMax - 1) : wpos_q - AddrBits'(1);
          left_d   = FillBits'(item_i.len) - FillBits'(1);
          if (32'(fill_inc) >= 32'(item_i.len)) begin
            seen_d  = 1'b1;
            state_d = BeScan;
          end else begin
            state_d = BeDone;
          end
        end
      end
      BeScan: begin
        // one read issued and one sample folded per cycle
        if (rd_pend_q) begin
          if ($signed(ram_rdata) > $signed(hi_q)) hi_d = ram_rdata;
          if ($signed(ram_rdata) < $signed(lo_q)) lo_d = ram_rdata;
        end
        if (left_q != '0) begin
          rd_pend_d = 1'b1;
          left_d    = left_q - FillBits'(1);
          raddr_d   = (raddr_q == '0) ? AddrBits'(WindowMax - 1) : raddr_q - AddrBits'(1);
        end else if (!rd_pend_q) begin
          if (range > best_q) best_d = range;
          state_d = BeDone;
        end
      end
      BeDone: begin
        if (!last_q) begin
          state_d = BeIdle;
        end else if (!ovalid_d) begin
          ovalid_d = 1'b1;
          obest_d  = best_q;
          ohad_d   = seen_q;
          fill_d   = '0;
          best_d   = '0;
          wpos_d   = '0;
          seen_d   = 1'b0;
          state_d  = BeIdle;
        end
      end
      default: state_d = BeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BeIdle;
      wpos_q    <= '0;
      fill_q    <= '0;
      best_q    <= '0;
      seen_q    <= 1'b0;
      rd_pend_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      wpos_q    <= wpos_d;
      fill_q    <= fill_d;
      best_q    <= best_d;
      seen_q    <= seen_d;
      rd_pend_q <= rd_pend_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    left_q  <= left_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    last_q  <= last_d;
    obest_q <= obest_d;
    ohad_q  <= ohad_d;
  end

endmodule

[sv/sliding_window_peak_range_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_peak_range_core: largest max-minus-min over sliding windows
// Front end queues samples, back end scans each window in the sample RAM.
//
//   channel  | signals                              | direction
//   sample   | in_valid_i/in_ready_o, sample_i,     | in
//            | last_sample_i                        |
//   result   | out_valid_o/out_ready_i,             | out
//            | best_range_o, had_window_o           |
//   config   | cfg_we_i, cfg_wdata_i                | in
//
// The window scan reads the sample RAM once per cycle through its single port,
// and the RAM read data is registered; the back end takes no new item until
// its scan of the last one is done.
// Reset clears counts and the best range; RAM contents need no clearing.
// A stalled result holds the back end only on the last sample of a set;
// the two-entry queue takes up to two more samples meanwhile.
// ----------------------------------------------------------------------------
module sliding_window_peak_range_core #(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swpr_pkg::CfgBits-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  sample_i,
  input  logic                         last_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  best_range_o,
  output logic                         had_window_o
);
  import swpr_pkg::*;

  logic [CfgBits-1:0] window_len_q;
  swpr_item_t item;
  logic item_valid, item_ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= CfgBits'(1);
    end else if (cfg_we_i) begin
      window_len_q <= cfg_wdata_i;
    end
  end

  swpr_front #(.WindowMax(WINDOW_MAX), .SampleBits(SAMPLE_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_len_q_i(window_len_q),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready)
  );

  swpr_back #(.WindowMax(WINDOW_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .best_range_o(best_range_o),
    .had_window_o(had_window_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

[sv/swpr_checker.sv]
// ----------------------------------------------------------------------------
// swpr_checker: port-level checks
// Watches the result channel and the intake handshake over time.
// ----------------------------------------------------------------------------
module swpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_sample_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] best_range_o,
  input logic        had_window_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_range_o)
      && $stable(had_window_o))
    else $error("result changed while stalled");

  // no full window means a zero range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !had_window_o |-> best_range_o == 32'd0)
    else $error("nonzero range without a window");

  // a waiting sample transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(last_sample_i))
    else $error("sample dropped while waiting");

  // out of reset no result is pending
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o || !rst_ni)
    else $error("result valid after reset");

endmodule

bind sliding_window_peak_range_core swpr_checker u_swpr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_sample_i(last_sample_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .best_range_o (best_range_o),
  .had_window_o (had_window_o)
);

[tb/sv/sliding_window_peak_range_core_tb.sv]
// ----------------------------------------------------------------------------
// sliding_window_peak_range_core_tb: self-checking bench for the peak range core
// Sends sample sets with varied window lengths, predicts each set's best
// max-minus-min range and compares every result transfer against it.
// ----------------------------------------------------------------------------
module sliding_window_peak_range_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WinMax = 1024;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic [31:0] range;
    logic        seen;
  } set_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [swpr_pkg::CfgBits-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [31:0]                  sample_i = '0;
  logic                         last_sample_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [31:0]                  best_range_o;
  logic                         had_window_o;

  sliding_window_peak_range_core #(
    .WINDOW_MAX (WinMax),
    .SAMPLE_BITS(32)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .sample_i, .last_sample_i, .out_valid_o, .out_ready_i, .best_range_o,
    .had_window_o
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] hist_q [WinMax];
  int unsigned        fill_q, wpos_q;
  logic [31:0]        peak_q;
  logic               seen_q;
  logic [10:0]        win_len_q = 11'd1;
  set_result_t        pending_ranges [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void clear_set_model();
    fill_q = 0;
    wpos_q = 0;
    peak_q = '0;
    seen_q = 1'b0;
  endfunction

  // per-sample prediction, pushes an expected result on the last sample
  function automatic void predict_sample(input logic [31:0] s, input logic last);
    int unsigned len;
    logic signed [32:0] hi, lo, v;
    logic [31:0] rng;
    len = (win_len_q == 0) ? 1 : (win_len_q > WinMax ? WinMax : win_len_q);
    hist_q[wpos_q] = s;
    wpos_q = (wpos_q + 1) % WinMax;
    if (fill_q < WinMax) fill_q++;
    if (fill_q >= len) begin
      hi = $signed(s);
      lo = $signed(s);
      for (int unsigned i = 1; i <= len; i++) begin
        v = hist_q[(wpos_q + WinMax - i) % WinMax];
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
      rng = 32'(hi - lo);
      if (rng > peak_q) peak_q = rng;
      seen_q = 1'b1;
    end
    if (last) begin
      pending_ranges.push_back('{range: peak_q, seen: seen_q});
      clear_set_model();
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk_i) begin
    set_result_t exp_r;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("sliding_window_peak_range_core_tb NOT OK");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ranges.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        exp_r = pending_ranges.pop_front();
        if (best_range_o !== exp_r.range)
          report_mismatch($sformatf("best_range %0d exp %0d", best_range_o, exp_r.range));
        if (had_window_o !== exp_r.seen)
          report_mismatch($sformatf("had_window %0b exp %0b", had_window_o, exp_r.seen));
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one sample transfer, valid stays up for a back-to-back follower
  task automatic send_sample(input logic [31:0] s, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_sample_i <= last;
    predict_sample(s, last);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_ranges.size() != 0) @(negedge clk_i);
    repeat (WinMax + 20) @(negedge clk_i);
  endtask

  task automatic set_window(input logic [10:0] len);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    win_len_q = len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return 32'h8000_0000 + $urandom_range(7);
      1: return 32'h7fff_fff8 + $urandom_range(7);
      2: return $urandom_range(40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // directed: extremes, zero and oversize lengths, short sets
  task automatic test_directed();
    set_window(11'd1);
    send_sample(32'h8000_0000, 1'b1);
    set_window(11'd2);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b1);
    send_sample(32'hffff_ffff, 1'b1);
    set_window(11'd0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    set_window(11'd3);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'hffff_fffb, 1'b1);
    set_window(11'h7ff);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'hedcb_a987, 1'b1);
    set_window(11'd1024);
    for (int i = 0; i < 4; i++) send_sample(32'h5555_5555 ^ {32{i[0]}}, 1'b0);
    send_sample(32'h0, 1'b1);
  endtask

  // length change in the middle of a set
  task automatic test_len_change();
    set_window(11'd4);
    for (int i = 0; i < 5; i++) send_sample(rand_sample(), 1'b0);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 11'd2;
    win_len_q = 11'd2;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 3; i++) send_sample(rand_sample(), i == 2);
  endtask

  // random sets, mostly short windows, a few long
  task automatic test_random(input int n_items);
    int sent, set_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) set_window(11'($urandom_range(700, 1100)));
      else set_window(11'($urandom_range(8)));
      repeat ($urandom_range(1, 3)) begin
        set_len = $urandom_range(1, 14);
        for (int i = 0; i < set_len; i++) send_sample(rand_sample(), i == set_len - 1);
        sent += set_len;
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    clear_set_model();
    @(negedge clk_i);
    send_idle_pct = 31;
    recv_idle_pct = 54;
    test_directed();
    test_len_change();
    test_random(250);
    send_idle_pct = 54;
    recv_idle_pct = 31;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    drain_results();
    if (errors == 0) begin
      $display("sliding_window_peak_range_core_tb OK");
    end else begin
      $display("sliding_window_peak_range_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[sliding_window_peak_range_core.f]
sv/swpr_pkg.sv
sv/swpr_ram.sv
sv/swpr_front.sv
sv/swpr_back.sv
sv/sliding_window_peak_range_core.sv
sv/swpr_checker.sv
tb/sv/sliding_window_peak_range_core_tb.sv
